/* rtl/pidrc_pkg.sv */
package pidrc_pkg;

   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 4;
   localparam int STEP_W    = 3;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_KP        = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KI        = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KD        = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ILIM      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_OLIM      = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATE = CSR_IDX_W'(7);

   // register reset values, Q16.16 unless noted
   localparam logic signed [31:0] KP_RESET        = 32'sd2621;     // 0.04
   localparam logic signed [31:0] KI_RESET        = 32'sd0;
   localparam logic signed [31:0] KD_RESET        = 32'sd3932;     // 0.06
   localparam logic [30:0]        ILIM_RESET      = 31'd0;
   localparam logic [30:0]        OLIM_RESET      = 31'd6553600;   // 100.0
   localparam logic signed [31:0] OFFSET_RESET    = 32'sd0;
   localparam logic [23:0]        STEP_TIME_RESET = 24'd16777;     // Q0.24, 1 ms
   localparam logic [15:0]        STEP_RATE_RESET = 16'd1000;      // Hz

   // microprogram step addresses
   localparam logic [STEP_W-1:0] STEP_IDLE   = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_MUL_I  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_MUL_D  = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_MUL_KP = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_MUL_KI = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_MUL_KD = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_SUM    = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_FINISH = STEP_W'(7);

   typedef enum logic [2:0] {
      A_E, A_DIFF, A_KP, A_KI, A_KD
   } a_sel_type;

   typedef enum logic [2:0] {
      B_ST, B_RATE, B_E, B_IVAL, B_DVAL
   } b_sel_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_INC, ACT_DSAT, ACT_ACC_LOAD, ACT_ACC_ADD, ACT_FINISH
   } act_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_WAIT_REQ, JMP_WAIT_RSP
   } jump_type;

   typedef struct packed {
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      act_type           act;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   // Steps MUL_I to MUL_KD each start one product, and steps MUL_D to SUM each consume the product of the step before.
   function automatic ctrl_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{a_sel: A_E, b_sel: B_ST, act: ACT_NONE, jump: JMP_NEXT, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            w.jump   = JMP_WAIT_REQ;
            w.target = STEP_MUL_I;
         end
         STEP_MUL_I: begin
            w.a_sel = A_E;
            w.b_sel = B_ST;
         end
         STEP_MUL_D: begin
            w.a_sel = A_DIFF;
            w.b_sel = B_RATE;
            w.act   = ACT_INC;
         end
         STEP_MUL_KP: begin
            w.a_sel = A_KP;
            w.b_sel = B_E;
            w.act   = ACT_DSAT;
         end
         STEP_MUL_KI: begin
            w.a_sel = A_KI;
            w.b_sel = B_IVAL;
            w.act   = ACT_ACC_LOAD;
         end
         STEP_MUL_KD: begin
            w.a_sel = A_KD;
            w.b_sel = B_DVAL;
            w.act   = ACT_ACC_ADD;
         end
         STEP_SUM: begin
            w.act = ACT_ACC_ADD;
         end
         STEP_FINISH: begin
            w.act    = ACT_FINISH;
            w.jump   = JMP_WAIT_RSP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/pidrc_req_if.sv */
interface pidrc_req_if;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic signed [31:0] error_value;

   modport source (output valid, output cmd, output error_value, input ready);
   modport sink   (input valid, input cmd, input error_value, output ready);
endinterface

/* rtl/pidrc_rsp_if.sv */
interface pidrc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] drive_value;

   modport source (output valid, output drive_value, input ready);
   modport sink   (input valid, input drive_value, output ready);
endinterface

/* rtl/pidrc_csr_if.sv */
interface pidrc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pidrc_pkg::CSR_IDX_W-1:0]  index;
   logic [pidrc_pkg::DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pidrc_seq.sv */
module pidrc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                out_free,
   output pidrc_pkg::ctrl_type ctrl
);
   import pidrc_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      step_in = step_ff;
      unique case (ctrl.jump)
         JMP_NEXT:     step_in = STEP_W'(step_ff + 1'b1);
         JMP_WAIT_REQ: if (start) step_in = ctrl.target;
         JMP_WAIT_RSP: if (out_free) step_in = ctrl.target;
         default:      step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* rtl/pid_regulator_clamped.sv */
// Single PID channel in signed Q16.16. An update transaction (cmd 0) carries an
// error sample and yields one drive value: a microprogram of eight steps feeds
// one shared 33x33 multiplier five products (error*step_time, delta*step_rate,
// kp*e, ki*I, kd*D), one per cycle, and folds each into the integral, derivative
// or output accumulator the next cycle. The next transaction is taken only once
// the microprogram is back at its idle step, so updates do not overlap; a result
// that is not taken holds in the output register and stalls only the final step
// of the following update. A clear transaction (cmd 1) zeroes the integral and
// previous error and gives no result. Write csr_bus only while the block is
// idle; indexes 0..7 select kp, ki, kd, integral limit, output limit, output
// offset, step time (Q0.24) and step rate (Hz), others are ignored.
module pid_regulator_clamped (
   input logic         clock,
   input logic         reset,
   pidrc_req_if.sink   req_bus,
   pidrc_rsp_if.source rsp_bus,
   pidrc_csr_if.sink   csr_bus
);
   import pidrc_pkg::*;

   // configuration
   logic signed [31:0] kp_ff, kp_in;
   logic signed [31:0] ki_ff, ki_in;
   logic signed [31:0] kd_ff, kd_in;
   logic [30:0]        ilim_ff, ilim_in;
   logic [30:0]        olim_ff, olim_in;
   logic signed [31:0] offset_ff, offset_in;
   logic [23:0]        st_ff, st_in;
   logic [15:0]        rate_ff, rate_in;

   // state and datapath
   logic signed [31:0] isum_ff, isum_in;
   logic signed [31:0] prev_ff, prev_in;
   logic signed [31:0] e_ff, e_in;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [31:0] ival_ff, ival_in;
   logic signed [31:0] dval_ff, dval_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [31:0] drive_ff, drive_in;
   logic               rsp_valid_ff, rsp_valid_in;

   ctrl_type           ctrl;
   logic               upd_accept;
   logic               clr_accept;
   logic               out_free;
   logic               finish_fire;

   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] full_prod;
   logic signed [31:0] inc;
   logic signed [32:0] isum_ext;
   logic signed [32:0] inc_ext;
   logic signed [32:0] isum_sum;
   logic signed [32:0] ilim_pos;
   logic signed [32:0] ilim_neg;
   logic signed [32:0] olim_pos;
   logic signed [32:0] olim_neg;
   logic signed [31:0] ival_clamp;
   logic signed [31:0] dval_sat;
   logic signed [47:0] term;
   logic signed [49:0] term_ext;
   logic signed [49:0] offset_ext;
   logic signed [31:0] acc_sat;
   logic signed [32:0] acc_sat_ext;
   logic signed [31:0] drive_clamp;
   logic signed [32:0] e_ext;
   logic signed [32:0] prev_ext;

   assign upd_accept  = req_bus.valid && req_bus.ready && !req_bus.cmd;
   assign clr_accept  = req_bus.valid && req_bus.ready && req_bus.cmd;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign finish_fire = (ctrl.act == ACT_FINISH) && out_free;

   assign req_bus.ready       = (ctrl.jump == JMP_WAIT_REQ);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.drive_value = drive_ff;
   assign csr_bus.ready       = 1'b1;

   pidrc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (upd_accept),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   // shared multiplier operands
   always_comb begin
      case (ctrl.a_sel)
         A_E:     mul_a = {e_ff[31], e_ff};
         A_DIFF:  mul_a = diff_ff;
         A_KP:    mul_a = {kp_ff[31], kp_ff};
         A_KI:    mul_a = {ki_ff[31], ki_ff};
         A_KD:    mul_a = {kd_ff[31], kd_ff};
         default: mul_a = '0;
      endcase
      case (ctrl.b_sel)
         B_ST:    mul_b = {9'd0, st_ff};
         B_RATE:  mul_b = {17'd0, rate_ff};
         B_E:     mul_b = {e_ff[31], e_ff};
         B_IVAL:  mul_b = {ival_ff[31], ival_ff};
         B_DVAL:  mul_b = {dval_ff[31], dval_ff};
         default: mul_b = '0;
      endcase
   end

   assign full_prod = mul_a * mul_b;
   assign prod_in   = full_prod[63:0];

   // integral: floor shift by 24 is a bit select; the sum always fits 33 bits
   assign inc      = prod_ff[55:24];
   assign isum_ext = {isum_ff[31], isum_ff};
   assign inc_ext  = {inc[31], inc};
   assign isum_sum = isum_ext + inc_ext;
   assign ilim_pos = {2'b00, ilim_ff};
   assign ilim_neg = -ilim_pos;
   assign olim_pos = {2'b00, olim_ff};
   assign olim_neg = -olim_pos;

   always_comb begin
      if (isum_sum > ilim_pos) begin
         ival_clamp = ilim_pos[31:0];
      end else if (isum_sum < ilim_neg) begin
         ival_clamp = ilim_neg[31:0];
      end else begin
         ival_clamp = isum_sum[31:0];
      end
   end

   // saturate the derivative product to 32 bits
   always_comb begin
      if ((&prod_ff[63:31]) || !(|prod_ff[63:31])) begin
         dval_sat = prod_ff[31:0];
      end else if (prod_ff[63]) begin
         dval_sat = 32'sh8000_0000;
      end else begin
         dval_sat = 32'sh7FFF_FFFF;
      end
   end

   assign term       = prod_ff[63:16];
   assign term_ext   = {{2{term[47]}}, term};
   assign offset_ext = {{18{offset_ff[31]}}, offset_ff};

   always_comb begin
      if ((&acc_ff[49:31]) || !(|acc_ff[49:31])) begin
         acc_sat = acc_ff[31:0];
      end else if (acc_ff[49]) begin
         acc_sat = 32'sh8000_0000;
      end else begin
         acc_sat = 32'sh7FFF_FFFF;
      end
   end

   assign acc_sat_ext = {acc_sat[31], acc_sat};

   always_comb begin
      if (acc_sat_ext > olim_pos) begin
         drive_clamp = olim_pos[31:0];
      end else if (acc_sat_ext < olim_neg) begin
         drive_clamp = olim_neg[31:0];
      end else begin
         drive_clamp = acc_sat;
      end
   end

   assign e_ext    = {req_bus.error_value[31], req_bus.error_value};
   assign prev_ext = {prev_ff[31], prev_ff};

   // datapath next state
   always_comb begin
      isum_in      = isum_ff;
      prev_in      = prev_ff;
      e_in         = e_ff;
      diff_in      = diff_ff;
      ival_in      = ival_ff;
      dval_in      = dval_ff;
      acc_in       = acc_ff;
      drive_in     = drive_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (upd_accept) begin
         e_in    = req_bus.error_value;
         diff_in = e_ext - prev_ext;
      end
      if (clr_accept) begin
         isum_in = '0;
         prev_in = '0;
      end

      case (ctrl.act)
         ACT_INC:      ival_in = ival_clamp;
         ACT_DSAT:     dval_in = dval_sat;
         ACT_ACC_LOAD: acc_in  = offset_ext + term_ext;
         ACT_ACC_ADD:  acc_in  = acc_ff + term_ext;
         ACT_FINISH: begin
            if (finish_fire) begin
               drive_in     = drive_clamp;
               rsp_valid_in = 1'b1;
               isum_in      = ival_ff;
               prev_in      = e_ff;
            end
         end
         default: ;
      endcase
   end

   // configuration writes; out-of-range indexes drop
   always_comb begin
      kp_in     = kp_ff;
      ki_in     = ki_ff;
      kd_in     = kd_ff;
      ilim_in   = ilim_ff;
      olim_in   = olim_ff;
      offset_in = offset_ff;
      st_in     = st_ff;
      rate_in   = rate_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_KP:        kp_in     = csr_bus.data;
            CSR_KI:        ki_in     = csr_bus.data;
            CSR_KD:        kd_in     = csr_bus.data;
            CSR_ILIM:      ilim_in   = csr_bus.data[30:0];
            CSR_OLIM:      olim_in   = csr_bus.data[30:0];
            CSR_OFFSET:    offset_in = csr_bus.data;
            CSR_STEP_TIME: st_in     = csr_bus.data[23:0];
            CSR_STEP_RATE: rate_in   = csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= KP_RESET;
         ki_ff        <= KI_RESET;
         kd_ff        <= KD_RESET;
         ilim_ff      <= ILIM_RESET;
         olim_ff      <= OLIM_RESET;
         offset_ff    <= OFFSET_RESET;
         st_ff        <= STEP_TIME_RESET;
         rate_ff      <= STEP_RATE_RESET;
         isum_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         ilim_ff      <= ilim_in;
         olim_ff      <= olim_in;
         offset_ff    <= offset_in;
         st_ff        <= st_in;
         rate_ff      <= rate_in;
         isum_ff      <= isum_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      diff_ff  <= diff_in;
      ival_ff  <= ival_in;
      dval_ff  <= dval_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      drive_ff <= drive_in;
   end

`ifndef SYNTHESIS
   // a result appears only from the final microprogram step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(ctrl.act == ACT_FINISH))
      else $error("result raised outside the finish step");

   // an update occupies the sequencer, so no second transaction is taken next cycle
   assert property (@(posedge clock) disable iff (reset)
      upd_accept |=> !req_bus.ready)
      else $error("sequencer took a transaction while busy");

   // clear zeroes both state registers
   assert property (@(posedge clock) disable iff (reset)
      clr_accept |=> (isum_ff == 32'sd0) && (prev_ff == 32'sd0))
      else $error("clear did not zero the state");

   // a waiting drive value stays inside the output limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         ($signed({rsp_bus.drive_value[31], rsp_bus.drive_value}) <= olim_pos)
         && ($signed({rsp_bus.drive_value[31], rsp_bus.drive_value}) >= olim_neg))
      else $error("drive value outside the output limit");
`endif

endmodule
